@@ design/olid_pkg.sv @@
// ----------------------------------------------------------------------------
// olid_pkg : shared types and constants for the ordered list block
// Request, place and status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package olid_pkg;

   // default sizes of the list
   localparam int DEPTH_DEF      = 32;
   localparam int DATA_WIDTH_DEF = 32;

   // widths of the port fields
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int OIDX_W  = 5;
   localparam int COUNT_W = 6;
   localparam int STAT_W  = 3;

   // index width carried in cell commands, wide enough for the largest list
   localparam int IDX_W = 7;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      PLACE_HEAD = 2'd0,
      PLACE_TAIL = 2'd1,
      PLACE_POS  = 2'd2
   } place_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_BAD_POS   = 3'd3,
      STAT_BAD_PLACE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] at;
      logic [IDX_W-1:0] tail;
   } cell_cmd_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } fsm_state_type;

endpackage

@@ design/olid_cell.sv @@
// ----------------------------------------------------------------------------
// olid_cell : one storage cell of the list
// Holds one entry and takes a new word from itself, a neighbour, the head
// cell or the insert data, as the broadcast command and its own index say.
// ----------------------------------------------------------------------------
module olid_cell
   import olid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int INDEX      = 0
) (
   input  logic                         clock,
   input  cell_cmd_type                 cmd,
   input  logic signed [DATA_WIDTH-1:0] ins_data,
   input  logic signed [DATA_WIDTH-1:0] left_data,
   input  logic signed [DATA_WIDTH-1:0] right_data,
   input  logic signed [DATA_WIDTH-1:0] head_data,
   output logic signed [DATA_WIDTH-1:0] data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;

   // pick the next word for this cell
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (MY_IDX == cmd.at) begin
               data_in = ins_data;
            end else if (MY_IDX > cmd.at) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= cmd.at) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            if (MY_IDX == cmd.tail) begin
               data_in = head_data;
            end else begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ design/olid_ctrl.sv @@
// ----------------------------------------------------------------------------
// olid_ctrl : request decode, read-out sequencer and result register
// Checks each request, keeps the entry count, drives the cell row and
// holds each result until the far side takes the transfer.
// ----------------------------------------------------------------------------
module olid_ctrl
   import olid_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [1:0]                   req_place,
   input  logic [POS_W-1:0]             req_position,
   input  logic signed [DATA_WIDTH-1:0] head_data,
   output cell_cmd_type                 cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_W-1:0]    rsp_out_value,
   output logic [OIDX_W-1:0]            rsp_out_index,
   output logic                         rsp_last,
   output logic [STAT_W-1:0]            rsp_status,
   output logic [COUNT_W-1:0]           rsp_entry_count
);

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int RD_W  = $clog2(DEPTH);
   localparam int CMP_W = IDX_W + 1;

   fsm_state_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [RD_W-1:0]  rd_ff, rd_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [OIDX_W-1:0]         index_ff, index_in;
   logic                      last_ff, last_in;
   status_type                status_ff, status_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   logic slot_free;
   logic accept;
   logic rsp_load;
   logic rd_last;

   // decoded insert and delete
   status_type       ins_status, del_status;
   logic [IDX_W-1:0] ins_at, del_at;
   logic [CMP_W-1:0] pos_w, len_w;
   logic             list_full;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && (state_ff == S_IDLE) && slot_free;
   assign rd_last   = (LEN_W'(rd_ff) + LEN_W'(1)) == len_ff;
   assign pos_w     = CMP_W'(req_position);
   assign len_w     = CMP_W'(len_ff);
   assign list_full = len_ff >= LEN_W'(DEPTH);

   // check an insert and find its cell
   always_comb begin
      ins_status = STAT_OK;
      ins_at     = '0;
      case (req_place)
         PLACE_HEAD: ins_at = '0;
         PLACE_TAIL: ins_at = IDX_W'(len_ff);
         PLACE_POS:  ins_at = IDX_W'(req_position) - IDX_W'(1);
         default:    ins_status = STAT_BAD_PLACE;
      endcase
      if (ins_status == STAT_OK) begin
         if (list_full) begin
            ins_status = STAT_FULL;
         end else if ((req_place == PLACE_POS) &&
                      ((pos_w == '0) || (pos_w > (len_w + CMP_W'(1))))) begin
            ins_status = STAT_BAD_POS;
         end
      end
   end

   // check a delete and find its cell
   always_comb begin
      del_status = STAT_OK;
      del_at     = '0;
      case (req_place)
         PLACE_HEAD: del_at = '0;
         PLACE_TAIL: del_at = IDX_W'(len_ff) - IDX_W'(1);
         PLACE_POS:  del_at = IDX_W'(req_position) - IDX_W'(1);
         default:    del_status = STAT_BAD_PLACE;
      endcase
      if (del_status == STAT_OK) begin
         if (len_ff == '0) begin
            del_status = STAT_EMPTY;
         end else if ((req_place == PLACE_POS) &&
                      ((pos_w == '0) || (pos_w > len_w))) begin
            del_status = STAT_BAD_POS;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind_type'(req_type) == REQ_READ) && (len_ff != '0)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (slot_free && rd_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs: cell command, count and result load
   always_comb begin
      req_stall = 1'b1;
      cmd.op    = CELL_HOLD;
      cmd.at    = '0;
      cmd.tail  = IDX_W'(len_ff) - IDX_W'(1);
      len_in    = len_ff;
      rd_in     = rd_ff;
      rsp_load  = 1'b0;
      value_in  = '0;
      index_in  = '0;
      last_in   = 1'b1;
      status_in = STAT_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = !slot_free;
            if (accept) begin
               rsp_load = 1'b1;
               unique case (req_kind_type'(req_type))
                  REQ_CLEAR: begin
                     len_in = '0;
                  end
                  REQ_INSERT: begin
                     status_in = ins_status;
                     if (ins_status == STAT_OK) begin
                        cmd.op = CELL_INSERT;
                        cmd.at = ins_at;
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  REQ_DELETE: begin
                     status_in = del_status;
                     if (del_status == STAT_OK) begin
                        cmd.op = CELL_DELETE;
                        cmd.at = del_at;
                        len_in = len_ff - LEN_W'(1);
                     end
                  end
                  REQ_READ: begin
                     if (len_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        rsp_load = 1'b0;
                        rd_in    = '0;
                     end
                  end
                  default: rsp_load = 1'b0;
               endcase
            end
         end
         S_READ: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               value_in = VALUE_W'(head_data);
               index_in = OIDX_W'(rd_ff);
               last_in  = rd_last;
               cmd.op   = CELL_ROTATE;
               rd_in    = rd_ff + RD_W'(1);
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign count_in     = COUNT_W'(len_in);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each new transfer
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         value_ff  <= value_in;
         index_ff  <= index_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = value_ff;
   assign rsp_out_index   = index_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(DEPTH))
      else $error("entry count beyond list depth");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (len_ff != '0))
      else $error("read-out running on an empty list");

   a_read_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_READ) && rsp_load && rd_last) |=> (state_ff == S_IDLE))
      else $error("read-out did not stop after its last entry");

   a_len_steady_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (len_ff == $past(len_ff)))
      else $error("entry count changed during read-out");

   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> req_stall)
      else $error("request taken during read-out");

endmodule

@@ design/ordered_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_delete : ordered list of signed words in a cell row
// Clears, inserts, deletes and reads out a list kept in a row of cells.
// ----------------------------------------------------------------------------
// Clear, insert and delete: result one cycle after the transfer, one per cycle.
// Insert and delete move every cell behind the changed place at once.
// Read-out of N entries: N results, one per unstalled cycle, by rotating the
// cell row; the next request is taken once the last entry is in the result
// register. Reset empties the list; the cell words themselves are not reset.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete
   import olid_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [1:0]                req_place,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [OIDX_W-1:0]         rsp_out_index,
   output logic                      rsp_last,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [COUNT_W-1:0]        rsp_entry_count
);

   cell_cmd_type                 cmd;
   logic signed [DATA_WIDTH-1:0] ins_data;
   logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];

   // fit the request word to the stored width
   assign ins_data = DATA_WIDTH'(req_value);

   olid_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_place       (req_place),
      .req_position    (req_position),
      .head_data       (cell_data[0]),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_index   (rsp_out_index),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // row of cells, each wired to both neighbours; the ends hold their own word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_w;
      logic signed [DATA_WIDTH-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = cell_data[i];
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end

      olid_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .ins_data   (ins_data),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

endmodule
